>>> sv/polyphase_fir_resampler_defines.svh
// assertion macros for the polyphase fir resampler
`ifndef POLYPHASE_FIR_RESAMPLER_DEFINES_SVH
`define POLYPHASE_FIR_RESAMPLER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define PFR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence that holds in the same cycle as its antecedent
`define PFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/pfr_pkg.sv
// shared types and constants of the polyphase fir resampler
`default_nettype none

package pfr_pkg;

    // coefficient format q2.15
    localparam int COEF_WIDTH = 18;
    localparam int COEF_FRAC  = 15;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int FACTOR_W   = 5;
    localparam int TAPS_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd2;

    // reset values of the registers
    localparam logic                DIRECTION_RST = 1'b0;
    localparam logic [FACTOR_W-1:0] FACTOR_RST    = 5'd2;
    localparam logic [TAPS_W-1:0]   TAP_COUNT_RST = 8'd67;

    // direction codes
    localparam logic DIR_DECIMATE    = 1'b0;
    localparam logic DIR_INTERPOLATE = 1'b1;

    // input word kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

endpackage

`default_nettype wire

>>> sv/pfr_mac.sv
// multiply-accumulate unit with rounding and saturation of the sum
`default_nettype none

module pfr_mac #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_TAPS     = 128
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire pfr_pkg::t_mac_ctl                       i_ctl,
    input  wire logic signed [pfr_pkg::COEF_WIDTH-1:0]   i_coef,
    input  wire logic signed [SAMPLE_WIDTH-1:0]          i_hist,
    output logic                                         o_busy,
    output logic signed [SAMPLE_WIDTH-1:0]               o_value
);

    localparam int PROD_W = SAMPLE_WIDTH + pfr_pkg::COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int RND_W  = ACC_W + 1;

    localparam logic signed [RND_W-1:0] HALF =
        RND_W'(1) << (pfr_pkg::COEF_FRAC - 1);
    localparam logic signed [RND_W-1:0] SAT_HI =
        {{(RND_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_LO =
        {{(RND_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic                     r_pv;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [RND_W-1:0]  rnd_sum;
    logic signed [RND_W-1:0]  rnd_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.valid;
        end
    end

    // product stage, then accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= PROD_W'(i_coef) * PROD_W'(i_hist);
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round half up, then clamp to the sample range
    always_comb begin
        rnd_sum   = RND_W'(r_acc) + HALF;
        rnd_shift = rnd_sum >>> pfr_pkg::COEF_FRAC;
        priority if (rnd_shift > SAT_HI) begin
            o_value = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (rnd_shift < SAT_LO) begin
            o_value = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            o_value = rnd_shift[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_busy = r_pv;

endmodule

`default_nettype wire

>>> sv/polyphase_fir_resampler.sv
// top level of the polyphase fir resampler (decimator / interpolator)
//
// input channel (i_s_*): one word per item; tuser selects a sample word or a
//   coefficient load word. a load word writes one entry of the coefficient
//   memory and gives no result. a sample word enters the history ring.
// output channel (o_m_*): filtered samples; tuser carries the place of the
//   result between input samples, tlast marks the final result of a sample.
// config channel (i_cfg_*): direction, factor and tap count, always ready; the user
//   writes them by index only while the block is idle, which the block does not enforce.
// timing: one shared multiplier walks the taps, one tap per cycle, reading the
//   coefficient and history memories. a sample that gives no output and a
//   load word leave the block idle, ready for the next word. otherwise the
//   next word is taken once the last result of the current one sits in the
//   output register.
// reset: registers return to direction 0, factor 2, tap count 67; history
//   reads as zero until written (a fill count, no clearing pass); the
//   coefficient memory holds nothing defined until loaded.
// stall: a result waits in the output register; the walk pauses before the
//   next result until the receiver takes the waiting word.
`default_nettype none

module polyphase_fir_resampler #(
    parameter int MAX_TAPS     = 128,
    parameter int MAX_FACTOR   = 16,
    parameter int SAMPLE_WIDTH = 16,
    localparam int ADDR_W      = $clog2(MAX_TAPS),
    localparam int PHW         = $clog2(MAX_FACTOR),
    localparam int IN_BITS     = SAMPLE_WIDTH + ADDR_W + pfr_pkg::COEF_WIDTH,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]            i_s_tdata,   // sample, coef_index, coef_value
    input  wire logic                             i_s_tuser,   // mode
    // output stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [OUT_TDATA_W-1:0]                o_m_tdata,   // value
    output logic [PHW-1:0]                        o_m_tuser,   // place
    output logic                                  o_m_tlast,
    // configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int FILL_W = $clog2(MAX_TAPS + 1);
    localparam int KW     = $clog2(MAX_TAPS + MAX_FACTOR);
    localparam int FCW    = $clog2(MAX_FACTOR + 1);
    localparam int CW     = pfr_pkg::COEF_WIDTH;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // configuration registers
    logic                          r_direction;
    logic [pfr_pkg::FACTOR_W-1:0]  r_factor;
    logic [pfr_pkg::TAPS_W-1:0]    r_tap_count;

    // effective settings after clamping
    logic [FCW-1:0]    f_eff;
    logic [FILL_W-1:0] taps_eff;
    logic [FCW-1:0]    step;
    logic [FCW-1:0]    phases;

    // input word fields
    logic [SAMPLE_WIDTH-1:0] s_sample;
    logic [ADDR_W-1:0]       s_cidx;
    logic [CW-1:0]           s_cval;
    logic                    s_acc;

    // sequencer state
    logic [1:0]        r_state,   n_state;
    logic [ADDR_W-1:0] r_wp,      n_wp;
    logic [ADDR_W-1:0] r_newest,  n_newest;
    logic [FILL_W-1:0] r_fill,    n_fill;
    logic [PHW-1:0]    r_phase,   n_phase;
    logic [PHW-1:0]    r_p,       n_p;
    logic [KW-1:0]     r_k,       n_k;
    logic [ADDR_W-1:0] r_age,     n_age;
    logic [ADDR_W-1:0] r_haddr,   n_haddr;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_value, n_out_value;
    logic [PHW-1:0]          r_out_place, n_out_place;
    logic                    r_out_last,  n_out_last;

    // strobes and helpers
    logic              issue;
    logic              mac_clear;
    logic              coef_we;
    logic              hist_we;
    logic              out_free;
    logic              hist_ok;
    logic              k_lt_taps;
    logic [KW-1:0]     k_next;
    logic [PHW:0]      p_plus;
    logic              p_last;
    logic [PHW:0]      ph_inc;
    logic              ph_reach;
    logic [ADDR_W-1:0] wp_inc;
    logic [ADDR_W-1:0] haddr_dec;

    // memories and their read registers
    logic [CW-1:0]           coef_mem [MAX_TAPS];
    logic [SAMPLE_WIDTH-1:0] hist_mem [MAX_TAPS];
    logic [CW-1:0]           r_coef_rd;
    logic [SAMPLE_WIDTH-1:0] r_hist_rd;
    logic                    r_rd_v;
    logic                    r_rd_ok;

    // multiply-accumulate interface
    pfr_pkg::t_mac_ctl              mac_ctl;
    logic                           mac_busy;
    logic signed [SAMPLE_WIDTH-1:0] mac_value;
    logic signed [SAMPLE_WIDTH-1:0] mac_hist;

    // unpack the input word
    assign s_sample = i_s_tdata[SAMPLE_WIDTH-1:0];
    assign s_cidx   = i_s_tdata[SAMPLE_WIDTH +: ADDR_W];
    assign s_cval   = i_s_tdata[SAMPLE_WIDTH + ADDR_W +: CW];

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= pfr_pkg::DIRECTION_RST;
            r_factor    <= pfr_pkg::FACTOR_RST;
            r_tap_count <= pfr_pkg::TAP_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pfr_pkg::REG_DIRECTION: r_direction <= i_cfg_data[0];
                pfr_pkg::REG_FACTOR:    r_factor    <= i_cfg_data[pfr_pkg::FACTOR_W-1:0];
                pfr_pkg::REG_TAP_COUNT: r_tap_count <= i_cfg_data[pfr_pkg::TAPS_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // clamp factor and tap count to what the hardware holds
    always_comb begin
        priority if (r_factor < pfr_pkg::FACTOR_W'(2)) begin
            f_eff = FCW'(2);
        end else if (32'(r_factor) > MAX_FACTOR) begin
            f_eff = FCW'(MAX_FACTOR);
        end else begin
            f_eff = FCW'(r_factor);
        end
        if (32'(r_tap_count) > MAX_TAPS) begin
            taps_eff = FILL_W'(MAX_TAPS);
        end else begin
            taps_eff = FILL_W'(r_tap_count);
        end
        // decimation walks every tap in one phase; interpolation strides by factor
        if (r_direction == pfr_pkg::DIR_INTERPOLATE) begin
            step   = f_eff;
            phases = f_eff;
        end else begin
            step   = FCW'(1);
            phases = FCW'(1);
        end
    end

    // address arithmetic
    assign wp_inc    = (r_wp == ADDR_W'(MAX_TAPS - 1)) ? '0 : r_wp + 1'b1;
    assign haddr_dec = (r_haddr == '0) ? ADDR_W'(MAX_TAPS - 1) : r_haddr - 1'b1;
    assign k_lt_taps = (r_k < KW'(taps_eff));
    assign k_next    = r_k + KW'(step);
    assign hist_ok   = (FILL_W'(r_age) < r_fill);
    assign p_plus    = (PHW + 1)'(r_p) + 1'b1;
    assign p_last    = (p_plus == (PHW + 1)'(phases));
    assign ph_inc    = (PHW + 1)'(r_phase) + 1'b1;
    assign ph_reach  = (ph_inc >= (PHW + 1)'(f_eff));
    assign out_free  = !r_out_valid || i_m_tready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_newest    = r_newest;
        n_fill      = r_fill;
        n_phase     = r_phase;
        n_p         = r_p;
        n_k         = r_k;
        n_age       = r_age;
        n_haddr     = r_haddr;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_place = r_out_place;
        n_out_last  = r_out_last;
        issue       = 1'b0;
        mac_clear   = 1'b0;
        coef_we     = 1'b0;
        hist_we     = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == pfr_pkg::MODE_COEF) begin
                        coef_we = (32'(s_cidx) < MAX_TAPS);
                    end else begin
                        hist_we  = 1'b1;
                        n_wp     = wp_inc;
                        n_newest = r_wp;
                        n_fill   = (r_fill == FILL_W'(MAX_TAPS)) ? r_fill : r_fill + 1'b1;
                        n_p      = '0;
                        n_k      = '0;
                        n_age    = '0;
                        n_haddr  = r_wp;
                        if (r_direction == pfr_pkg::DIR_INTERPOLATE) begin
                            mac_clear = 1'b1;
                            n_state   = ST_RUN;
                        end else if (ph_reach) begin
                            n_phase   = '0;
                            mac_clear = 1'b1;
                            n_state   = ST_RUN;
                        end else begin
                            n_phase = ph_inc[PHW-1:0];
                        end
                    end
                end
            end
            ST_RUN: begin
                // one tap per cycle; a phase with no taps falls straight through
                if (k_lt_taps) begin
                    issue   = 1'b1;
                    n_k     = k_next;
                    n_age   = r_age + 1'b1;
                    n_haddr = haddr_dec;
                end
                if (!k_lt_taps || !(k_next < KW'(taps_eff))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last product to land, then hand over the result
                if (!r_rd_v && !mac_busy && out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = mac_value;
                    n_out_place = (r_direction == pfr_pkg::DIR_INTERPOLATE) ? r_p : '0;
                    n_out_last  = p_last;
                    if (p_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_p       = p_plus[PHW-1:0];
                        n_k       = KW'(p_plus);
                        n_age     = '0;
                        n_haddr   = r_newest;
                        mac_clear = 1'b1;
                        n_state   = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_rd_v      <= issue;
        end
    end

    // sequencer payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_newest    <= n_newest;
        r_p         <= n_p;
        r_k         <= n_k;
        r_age       <= n_age;
        r_haddr     <= n_haddr;
        r_out_value <= n_out_value;
        r_out_place <= n_out_place;
        r_out_last  <= n_out_last;
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            coef_mem[s_cidx] <= s_cval;
        end
        if (issue) begin
            r_coef_rd <= coef_mem[r_k[ADDR_W-1:0]];
        end
    end

    // history ring
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[r_wp] <= s_sample;
        end
        if (issue) begin
            r_hist_rd <= hist_mem[r_haddr];
            r_rd_ok   <= hist_ok;
        end
    end

    // ages never written since reset read as zero
    assign mac_hist = r_rd_ok ? $signed(r_hist_rd) : '0;
    assign mac_ctl  = '{clear: mac_clear, valid: r_rd_v};

    pfr_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_TAPS     (MAX_TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  ($signed(r_coef_rd)),
        .i_hist  (mac_hist),
        .o_busy  (mac_busy),
        .o_value (mac_value)
    );

    // output stream
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_value);
    assign o_m_tuser  = r_out_place;
    assign o_m_tlast  = r_out_last;

    `include "polyphase_fir_resampler_defines.svh"

    `PFR_ASSERT_ALWAYS(a_fill_bound, r_fill <= FILL_W'(MAX_TAPS), "history fill count beyond depth")
    `PFR_ASSERT_IMPL(a_ready_pipe_empty, o_s_tready, !r_rd_v && !mac_busy, "word taken while taps in flight")
    `PFR_ASSERT_IMPL(a_clear_pipe_empty, mac_clear, !r_rd_v && !mac_busy, "accumulator cleared with taps in flight")

endmodule

`default_nettype wire

>>> tb/sv/pfr_checker.sv
`timescale 1ns / 100ps
// result checker of the polyphase fir resampler: shadow filter, expected queue, field compare
module pfr_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [47:0]                    i_s_tdata,   // sample, coef_index, coef_value
    input  wire logic                           i_s_tuser,   // mode
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [15:0]                    i_m_tdata,   // value
    input  wire logic [3:0]                     i_m_tuser,   // place
    input  wire logic                           i_m_tlast,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int SAMPLE_W   = 16;
    localparam int ADDR_W     = 7;
    localparam int TAPS_MAX   = 128;
    localparam int FACTOR_MIN = 2;
    localparam int FACTOR_MAX = 16;
    localparam int PLACE_W    = 4;
    localparam int COEF_W     = pfr_pkg::COEF_WIDTH;
    localparam int IDX_LSB    = SAMPLE_W;
    localparam int COEFV_LSB  = SAMPLE_W + ADDR_W;
    localparam longint ROUND_HALF = longint'(1) << (pfr_pkg::COEF_FRAC - 1);
    localparam longint OUT_MAX    = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN    = -OUT_MAX - 1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [PLACE_W-1:0]  place;
        logic                last;
    } t_fir_result;

    // shadow state of the filter
    logic signed [COEF_W-1:0]           coef_mem [TAPS_MAX];
    logic signed [SAMPLE_W-1:0]         hist_mem [TAPS_MAX];
    logic [ADDR_W-1:0]                  hist_wr;
    int                                 phase;
    logic                               dir_reg;
    logic [pfr_pkg::FACTOR_W-1:0]       factor_reg;
    logic [pfr_pkg::TAPS_W-1:0]         taps_reg;
    t_fir_result                        pending_results [$];

    function automatic int live_factor();
        if (factor_reg < FACTOR_MIN) return FACTOR_MIN;
        if (factor_reg > FACTOR_MAX) return FACTOR_MAX;
        return int'(factor_reg);
    endfunction

    function automatic int live_taps();
        if (taps_reg > TAPS_MAX) return TAPS_MAX;
        return int'(taps_reg);
    endfunction

    // coefficient k against the sample of the given age (age 0 is the newest)
    function automatic longint tap_product(int k, int age);
        logic [ADDR_W-1:0] slot;
        slot = hist_wr - ADDR_W'(1) - ADDR_W'(age);
        return longint'(coef_mem[k]) * longint'(hist_mem[slot]);
    endfunction

    // round half up at the q.15 point, then clamp to the sample range
    function automatic logic [SAMPLE_W-1:0] round_saturate(longint acc);
        longint r;
        r = (acc + ROUND_HALF) >>> pfr_pkg::COEF_FRAC;
        if (r > OUT_MAX) r = OUT_MAX;
        else if (r < OUT_MIN) r = OUT_MIN;
        return r[SAMPLE_W-1:0];
    endfunction

    task automatic take_sample(logic signed [SAMPLE_W-1:0] s);
        int     f;
        int     taps;
        int     p;
        int     k;
        int     age;
        longint acc;
        f    = live_factor();
        taps = live_taps();
        hist_mem[hist_wr] = s;
        hist_wr = hist_wr + 1'b1;
        if (dir_reg == pfr_pkg::DIR_DECIMATE) begin
            phase++;
            if (phase >= f) begin
                phase = 0;
                acc = 0;
                for (k = 0; k < taps; k++) acc += tap_product(k, k);
                pending_results.push_back('{round_saturate(acc), '0, 1'b1});
            end
        end else begin
            for (p = 0; p < f; p++) begin
                acc = 0;
                age = 0;
                for (k = p; k < taps; k += f) begin
                    acc += tap_product(k, age);
                    age++;
                end
                pending_results.push_back('{round_saturate(acc), PLACE_W'(p), p == f - 1});
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_fir_result want;
        if (!i_rst_n) begin
            dir_reg    = pfr_pkg::DIRECTION_RST;
            factor_reg = pfr_pkg::FACTOR_RST;
            taps_reg   = pfr_pkg::TAP_COUNT_RST;
            hist_wr    = '0;
            phase      = 0;
            foreach (hist_mem[i]) hist_mem[i] = '0;
            foreach (coef_mem[i]) coef_mem[i] = '0;
            pending_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pfr_pkg::REG_DIRECTION: dir_reg    = i_cfg_data[0];
                    pfr_pkg::REG_FACTOR:    factor_reg = i_cfg_data[pfr_pkg::FACTOR_W-1:0];
                    pfr_pkg::REG_TAP_COUNT: taps_reg   = i_cfg_data[pfr_pkg::TAPS_W-1:0];
                    default: ;
                endcase
            end
            // results first: a word taken at this edge cannot belong to this edge's input
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected: value %0d place %0d last %0b",
                           $signed(i_m_tdata), i_m_tuser, i_m_tlast);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_m_tdata !== want.value) begin
                        $error("value: expected %0d, actual %0d",
                               $signed(want.value), $signed(i_m_tdata));
                        o_fail_count++;
                    end
                    if (i_m_tuser !== want.place) begin
                        $error("place: expected %0d, actual %0d", want.place, i_m_tuser);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == pfr_pkg::MODE_COEF) begin
                    coef_mem[i_s_tdata[COEFV_LSB-1:IDX_LSB]] =
                        i_s_tdata[COEFV_LSB+COEF_W-1:COEFV_LSB];
                end else begin
                    take_sample(i_s_tdata[SAMPLE_W-1:0]);
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench top of the polyphase fir resampler: stimulus, receiver stalls and verdict
module testbench;

    localparam int SAMPLE_W     = 16;
    localparam int ADDR_W       = 7;
    localparam int TAPS_MAX     = 128;
    localparam int COEF_W       = pfr_pkg::COEF_WIDTH;
    localparam int FACTOR_W     = pfr_pkg::FACTOR_W;
    localparam int TAPS_W       = pfr_pkg::TAPS_W;
    localparam int CFG_IDX_W    = pfr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = pfr_pkg::CFG_DATA_W;
    localparam int IN_TDATA_W   = ((SAMPLE_W + ADDR_W + COEF_W + 7) / 8) * 8;
    localparam int IDX_LSB      = SAMPLE_W;
    localparam int COEFV_LSB    = SAMPLE_W + ADDR_W;
    localparam int CLK_HALF     = 6;       // 12 ns period
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 16;     // covers a word with no result
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 84;      // enough for the four fixed phases

    // register index with nothing behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
    localparam logic [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

    // receiver stall styles
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} t_rx_style;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic [3:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int     fail_count;
    int     pending;
    bit     hold_request;   // set by the stimulus, taken and cleared by the receiver
    int     burst_left;
    longint cycle_count;

    polyphase_fir_resampler i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pfr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit, several times the slowest legal run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // receiver: switches between random stall styles, honors one long hold-off
    initial begin
        t_rx_style   style;
        int          style_left;
        int          hold_left;
        int          rx_tick;
        logic [7:0]  stall_pattern;
        m_tready      = 1'b0;
        style         = RX_FREE;
        style_left    = 0;
        hold_left     = 0;
        rx_tick       = 0;
        stall_pattern = 8'hff;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style         = t_rx_style'($urandom_range(RX_FREE, RX_PATTERN));
                    style_left    = $urandom_range(10, 80);
                    stall_pattern = 8'($urandom);
                end
                style_left--;
                case (style)
                    RX_FREE:  m_tready <= 1'b1;
                    RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
                    default:  m_tready <= stall_pattern[rx_tick % 8];
                endcase
                rx_tick++;
            end
        end
    end

    // fields into tdata, first field in the low bits, padding zero
    function automatic logic [IN_TDATA_W-1:0] pack_word(logic [SAMPLE_W-1:0] sample,
                                                        logic [ADDR_W-1:0] idx,
                                                        logic [COEF_W-1:0] cval);
        logic [IN_TDATA_W-1:0] w;
        w = '0;
        w[IDX_LSB-1:0]                  = sample;
        w[COEFV_LSB-1:IDX_LSB]          = idx;
        w[COEFV_LSB+COEF_W-1:COEFV_LSB] = cval;
        return w;
    endfunction

    // mostly moderate samples, a quarter over the full range
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        if ($urandom_range(0, 3) == 0) v = int'($urandom_range(0, 65535)) - 32768;
        else v = int'($urandom_range(0, 16383)) - 8192;
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        int v;
        if ($urandom_range(0, 3) == 0) v = int'($urandom_range(0, 262143)) - 131072;
        else v = int'($urandom_range(0, 8191)) - 4096;
        return COEF_W'(v);
    endfunction

    // one word on the input stream; starts and ends at a falling edge.
    // the sender runs in bursts with random gaps between them
    task automatic put_word(input logic mode, input logic [IN_TDATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= mode;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // unused fields of a word carry random bits
    task automatic put_sample(input logic [SAMPLE_W-1:0] sample);
        put_word(pfr_pkg::MODE_SAMPLE,
                 pack_word(sample, ADDR_W'($urandom), COEF_W'($urandom)));
    endtask

    task automatic put_coef(input logic [ADDR_W-1:0] idx, input logic [COEF_W-1:0] cval);
        put_word(pfr_pkg::MODE_COEF, pack_word(SAMPLE_W'($urandom), idx, cval));
    endtask

    // sender pauses until every expected word is out, then lets the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // registers change only with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        int                  i;
        int                  phase_no;
        int                  sent;
        int                  n;
        logic                dir;
        logic [FACTOR_W-1:0] fac;
        logic [TAPS_W-1:0]   taps;
        logic [COEF_W-1:0]   cval;

        // every input known from time zero
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = pfr_pkg::MODE_SAMPLE;
        cfg_valid    = 1'b0;
        cfg_index    = pfr_pkg::REG_DIRECTION;
        cfg_data     = '0;
        hold_request = 1'b0;
        burst_left   = 0;
        sent         = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill the whole coefficient table before any sample can read it
        for (i = 0; i < TAPS_MAX; i++) begin
            if (i == 0) cval = COEF_MAX;
            else if (i == 1) cval = COEF_MIN;
            else cval = pick_coef();
            put_coef(ADDR_W'(i), cval);
        end

        // reset settings: decimate by 2 over 67 taps, sample extremes
        put_sample(SAMPLE_MAX);
        put_sample(SAMPLE_MIN);
        put_sample(SAMPLE_MIN);
        put_sample(SAMPLE_MAX);
        // coefficient extremes at the top of the table
        put_coef(ADDR_W'(TAPS_MAX - 1), COEF_MAX);
        put_coef(ADDR_W'(TAPS_MAX - 2), COEF_MIN);

        // phase left at or above a lowered factor fires on the next sample
        write_reg(pfr_pkg::REG_FACTOR, 8'd16);
        repeat (5) put_sample(pick_sample());
        write_reg(pfr_pkg::REG_FACTOR, 8'd3);
        put_sample(pick_sample());
        put_sample(pick_sample());

        // factor below range acts as 2, zero tap count gives zero sums
        write_reg(pfr_pkg::REG_FACTOR, 8'd0);
        write_reg(pfr_pkg::REG_TAP_COUNT, 8'd0);
        put_sample(pick_sample());
        put_sample(pick_sample());

        // switch to interpolation keeping phase and history;
        // factor and tap count both above range, upper data bits set
        write_reg(pfr_pkg::REG_DIRECTION, {7'h7f, pfr_pkg::DIR_INTERPOLATE});
        write_reg(pfr_pkg::REG_FACTOR, 8'hff);
        write_reg(pfr_pkg::REG_TAP_COUNT, 8'hff);
        put_sample(SAMPLE_MAX);
        put_sample(SAMPLE_MIN);

        // tap count below factor: the upper places sum no taps
        write_reg(pfr_pkg::REG_TAP_COUNT, 8'd5);
        put_sample(pick_sample());

        // even tap count, then a single tap
        write_reg(pfr_pkg::REG_FACTOR, 8'd2);
        write_reg(pfr_pkg::REG_TAP_COUNT, 8'd4);
        put_sample(pick_sample());
        write_reg(pfr_pkg::REG_TAP_COUNT, 8'd1);
        put_sample(pick_sample());

        // a write to an index with no register, then back to decimation
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        write_reg(pfr_pkg::REG_DIRECTION, {7'h00, pfr_pkg::DIR_DECIMATE});
        put_sample(pick_sample());
        put_sample(pick_sample());

        // random phases: fixed extremes first, then random settings
        for (phase_no = 0; sent < RANDOM_ITEMS; phase_no++) begin
            case (phase_no)
                0: begin
                    dir = pfr_pkg::DIR_INTERPOLATE; fac = 5'd16; taps = 8'd128;
                end
                1: begin
                    dir = pfr_pkg::DIR_DECIMATE; fac = 5'd16; taps = 8'd128;
                end
                2: begin
                    dir = pfr_pkg::DIR_DECIMATE; fac = 5'd2; taps = 8'd1;
                end
                3: begin
                    dir = pfr_pkg::DIR_INTERPOLATE; fac = 5'd2; taps = 8'd127;
                end
                default: begin
                    dir  = ($urandom_range(0, 1) == 0) ? pfr_pkg::DIR_DECIMATE
                                                       : pfr_pkg::DIR_INTERPOLATE;
                    fac  = ($urandom_range(0, 5) == 0) ? FACTOR_W'($urandom_range(0, 31))
                                                       : FACTOR_W'($urandom_range(2, 16));
                    taps = ($urandom_range(0, 5) == 0) ? TAPS_W'($urandom_range(0, 255))
                                                       : TAPS_W'(2 * $urandom_range(0, 63) + 1);
                end
            endcase
            write_reg(pfr_pkg::REG_DIRECTION, {7'($urandom), dir});
            write_reg(pfr_pkg::REG_FACTOR, {3'($urandom), fac});
            write_reg(pfr_pkg::REG_TAP_COUNT, taps);

            // widest setting: receiver holds off while words keep coming,
            // so the output register fills and the input stalls
            if (phase_no == 0) hold_request = 1'b1;
            n = (phase_no == 0) ? 10 : $urandom_range(15, 35);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) put_coef(ADDR_W'($urandom), pick_coef());
                else put_sample(pick_sample());
                sent++;
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
